// ===== sv/lsgcd_pkg.sv =====
// lsgcd_pkg: shared constants, status codes and reset tables for the change dispenser
// used by limited_stock_greedy_change_dispenser and its checker, no dependencies
package lsgcd_pkg;

    localparam int NUM_SLOTS     = 5;
    localparam int NUM_REGS      = 5;
    localparam int NUM_OUT_SLOTS = 5;
    localparam int SLOT_W        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam int AMOUNT_W = 20;
    localparam int VALUE_W  = 16;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 3;

    localparam int DIV_STEPS = AMOUNT_W;
    localparam int BIT_W     = $clog2(DIV_STEPS);

    typedef logic [VALUE_W-1:0]  t_value;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [AMOUNT_W-1:0] t_amount;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_DISPENSED = 2'd0;
    localparam t_status ST_REFUSED   = 2'd1;
    localparam t_status ST_ACCEPTED  = 2'd2;
    localparam t_status ST_UNKNOWN   = 2'd3;

    localparam logic ACT_WITHDRAW = 1'b0;
    localparam logic ACT_DEPOSIT  = 1'b1;

    function automatic t_value f_value_reset(input int slot);
        t_value v;
        unique case (slot)
            0:       v = 16'd10;
            1:       v = 16'd20;
            2:       v = 16'd100;
            3:       v = 16'd200;
            4:       v = 16'd500;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_count f_stock_reset(input int slot);
        t_count c;
        unique case (slot)
            0:       c = 16'd10;
            1:       c = 16'd20;
            2:       c = 16'd0;
            3:       c = 16'd200;
            4:       c = 16'd50;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/limited_stock_greedy_change_dispenser.sv =====
// limited_stock_greedy_change_dispenser: note stock per slot, greedy withdraw, deposit
// depends on lsgcd_pkg; one shared restoring divider and one 16x16 multiplier
//
//  channel | direction | handshake                | payload
//  in      | to block  | i_in_valid / o_in_ready  | action, withdraw_amount, deposit_*
//  out     | from block| o_out_valid / i_out_ready| status, notes_slot_0..4
//  cfg     | to block  | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// deposit: the deposit state loads the result word once the result register is free
// withdraw: per slot a check that skips the slot, or a 20-step divider, multiply and subtract;
// the finish state then loads the result word once the result register is free
// the shared divider gives one quotient bit per cycle
// a new word is taken only when the previous one is done; a full result register holds the last step
// reset is synchronous active low and restores face values and note stock
module limited_stock_greedy_change_dispenser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_action,
    input  logic [lsgcd_pkg::AMOUNT_W-1:0]  i_withdraw_amount,
    input  logic [lsgcd_pkg::VALUE_W-1:0]   i_deposit_denomination,
    input  logic [lsgcd_pkg::COUNT_W-1:0]   i_deposit_count,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [lsgcd_pkg::STATUS_W-1:0]  o_status,
    output logic [lsgcd_pkg::COUNT_W-1:0]   o_notes_slot_0,
    output logic [lsgcd_pkg::COUNT_W-1:0]   o_notes_slot_1,
    output logic [lsgcd_pkg::COUNT_W-1:0]   o_notes_slot_2,
    output logic [lsgcd_pkg::COUNT_W-1:0]   o_notes_slot_3,
    output logic [lsgcd_pkg::COUNT_W-1:0]   o_notes_slot_4,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lsgcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lsgcd_pkg::VALUE_W-1:0]   i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_SUB   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_DEP   = 3'd6;

    logic [2:0] r_state, n_state;

    lsgcd_pkg::t_value  r_denom [lsgcd_pkg::NUM_SLOTS];
    lsgcd_pkg::t_count  r_stock [lsgcd_pkg::NUM_SLOTS];
    lsgcd_pkg::t_count  r_take  [lsgcd_pkg::NUM_SLOTS];

    logic [lsgcd_pkg::SLOT_W-1:0] r_slot;
    lsgcd_pkg::t_amount           r_rest;
    lsgcd_pkg::t_amount           r_div;
    lsgcd_pkg::t_value            r_rem;
    logic [lsgcd_pkg::BIT_W-1:0]  r_bit;
    logic [2*lsgcd_pkg::VALUE_W-1:0] r_prod;
    logic                         r_zero;
    lsgcd_pkg::t_value            r_dep_value;
    lsgcd_pkg::t_count            r_dep_count;

    logic                 r_out_valid;
    lsgcd_pkg::t_status   r_out_status;
    lsgcd_pkg::t_count    r_out_notes [lsgcd_pkg::NUM_OUT_SLOTS];

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_out_load;
    lsgcd_pkg::t_value    w_d;
    logic                 w_skip;
    logic [lsgcd_pkg::VALUE_W:0] w_trial;
    logic                 w_ge;
    lsgcd_pkg::t_count    w_stock_cur;
    lsgcd_pkg::t_count    w_take;
    logic                 w_dep_hit;
    logic [lsgcd_pkg::SLOT_W-1:0] w_dep_slot;
    logic                 w_last_bit;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_out_load  = ((r_state == S_FIN) || (r_state == S_DEP)) && w_out_free;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign w_d         = r_denom[r_slot];
    assign w_stock_cur = r_stock[r_slot];
    assign w_skip      = (w_d == '0) || ({{(lsgcd_pkg::AMOUNT_W-lsgcd_pkg::VALUE_W){1'b0}}, w_d}
                         > r_rest);
    assign w_trial     = {r_rem, r_div[lsgcd_pkg::AMOUNT_W-1]};
    assign w_ge        = (w_trial >= {1'b0, w_d});
    assign w_last_bit  = (r_bit == lsgcd_pkg::BIT_W'(lsgcd_pkg::DIV_STEPS - 1));
    assign w_take      = (r_div < {{(lsgcd_pkg::AMOUNT_W-lsgcd_pkg::COUNT_W){1'b0}}, w_stock_cur})
                         ? r_div[lsgcd_pkg::COUNT_W-1:0] : w_stock_cur;

    // lowest matching slot wins
    always_comb begin
        w_dep_hit  = 1'b0;
        w_dep_slot = '0;
        for (int i = lsgcd_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_denom[i] != '0 && r_denom[i] == r_dep_value) begin
                w_dep_hit  = 1'b1;
                w_dep_slot = lsgcd_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_action == lsgcd_pkg::ACT_DEPOSIT) begin
                        n_state = S_DEP;
                    end else if (i_withdraw_amount == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (!w_skip) begin
                    n_state = S_DIV;
                end else if (r_slot == '0) begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (w_last_bit) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_SUB;
            S_SUB: n_state = (r_slot == '0) ? S_FIN : S_CHECK;
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DEP: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < lsgcd_pkg::NUM_SLOTS; i++) begin
                r_denom[i] <= lsgcd_pkg::f_value_reset(i);
                r_stock[i] <= lsgcd_pkg::f_stock_reset(i);
            end
        end else begin
            r_state <= n_state;

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                for (int i = 0; i < lsgcd_pkg::NUM_SLOTS && i < lsgcd_pkg::NUM_REGS; i++) begin
                    if (i_cfg_index == lsgcd_pkg::CFG_IDX_W'(i)) begin
                        r_denom[i] <= i_cfg_data;
                    end
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_rest      <= i_withdraw_amount;
                        r_zero      <= (i_withdraw_amount == '0);
                        r_dep_value <= i_deposit_denomination;
                        r_dep_count <= i_deposit_count;
                        r_slot      <= lsgcd_pkg::SLOT_W'(lsgcd_pkg::NUM_SLOTS - 1);
                        for (int i = 0; i < lsgcd_pkg::NUM_SLOTS; i++) begin
                            r_take[i] <= '0;
                        end
                    end
                end
                S_CHECK: begin
                    if (!w_skip) begin
                        r_div <= r_rest;
                        r_rem <= '0;
                        r_bit <= '0;
                    end else if (r_slot != '0) begin
                        r_slot <= r_slot - 1'b1;
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? lsgcd_pkg::VALUE_W'(w_trial - {1'b0, w_d})
                                  : w_trial[lsgcd_pkg::VALUE_W-1:0];
                    r_div <= {r_div[lsgcd_pkg::AMOUNT_W-2:0], w_ge};
                    r_bit <= r_bit + 1'b1;
                end
                S_MUL: begin
                    r_take[r_slot] <= w_take;
                    r_prod         <= w_take * w_d;
                end
                S_SUB: begin
                    r_rest <= r_rest - r_prod[lsgcd_pkg::AMOUNT_W-1:0];
                    if (r_slot != '0) begin
                        r_slot <= r_slot - 1'b1;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        for (int j = 0; j < lsgcd_pkg::NUM_OUT_SLOTS; j++) begin
                            r_out_notes[j] <= (r_rest == '0 && !r_zero
                                               && j < lsgcd_pkg::NUM_SLOTS) ? r_take[j] : '0;
                        end
                        if (r_rest == '0 && !r_zero) begin
                            r_out_status <= lsgcd_pkg::ST_DISPENSED;
                            for (int i = 0; i < lsgcd_pkg::NUM_SLOTS; i++) begin
                                r_stock[i] <= r_stock[i] - r_take[i];
                            end
                        end else begin
                            r_out_status <= lsgcd_pkg::ST_REFUSED;
                        end
                    end
                end
                S_DEP: begin
                    if (w_out_free) begin
                        r_out_status <= w_dep_hit ? lsgcd_pkg::ST_ACCEPTED
                                                  : lsgcd_pkg::ST_UNKNOWN;
                        for (int j = 0; j < lsgcd_pkg::NUM_OUT_SLOTS; j++) begin
                            r_out_notes[j] <= '0;
                        end
                        // saturating add into the matching slot
                        for (int i = 0; i < lsgcd_pkg::NUM_SLOTS; i++) begin
                            if (w_dep_hit && w_dep_slot == lsgcd_pkg::SLOT_W'(i)) begin
                                r_stock[i] <= (({1'b0, r_stock[i]} + {1'b0, r_dep_count})
                                               > {1'b0, {lsgcd_pkg::COUNT_W{1'b1}}})
                                              ? {lsgcd_pkg::COUNT_W{1'b1}}
                                              : r_stock[i] + r_dep_count;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_notes_slot_0 = r_out_notes[0];
    assign o_notes_slot_1 = r_out_notes[1];
    assign o_notes_slot_2 = r_out_notes[2];
    assign o_notes_slot_3 = r_out_notes[3];
    assign o_notes_slot_4 = r_out_notes[4];

endmodule

// ===== sv/lsgcd_checker.sv =====
// lsgcd_checker: port-level assertions for the change dispenser
// depends on lsgcd_pkg; bound to limited_stock_greedy_change_dispenser
module lsgcd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [lsgcd_pkg::STATUS_W-1:0]  o_status,
    input logic [lsgcd_pkg::COUNT_W-1:0]   o_notes_slot_0,
    input logic [lsgcd_pkg::COUNT_W-1:0]   o_notes_slot_1,
    input logic [lsgcd_pkg::COUNT_W-1:0]   o_notes_slot_2,
    input logic [lsgcd_pkg::COUNT_W-1:0]   o_notes_slot_3,
    input logic [lsgcd_pkg::COUNT_W-1:0]   o_notes_slot_4
);

    // a result word waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped before accept");

    // busy after taking a word
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after accept");

    // only a dispense reports notes
    a_zero_notes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != lsgcd_pkg::ST_DISPENSED |->
        o_notes_slot_0 == '0 && o_notes_slot_1 == '0 && o_notes_slot_2 == '0
        && o_notes_slot_3 == '0 && o_notes_slot_4 == '0)
        else $error("notes reported without dispense");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind limited_stock_greedy_change_dispenser lsgcd_checker u_lsgcd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_notes_slot_0 (o_notes_slot_0),
    .o_notes_slot_1 (o_notes_slot_1),
    .o_notes_slot_2 (o_notes_slot_2),
    .o_notes_slot_3 (o_notes_slot_3),
    .o_notes_slot_4 (o_notes_slot_4)
);

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for limited_stock_greedy_change_dispenser
// holds a note ledger that predicts every result word, plus handshake drivers and a watchdog
// depends on lsgcd_pkg and the dispenser rtl only
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lsgcd_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int END_WAIT        = 150;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 240;

    typedef struct packed {
        t_status                     status;
        t_count [NUM_OUT_SLOTS-1:0] notes;
    } t_payout;

    class cash_ledger;
        t_value  face [NUM_SLOTS];
        t_count  stock [NUM_SLOTS];
        t_payout owed [$];
        int      mismatches;

        function new();
            face  = '{16'd10, 16'd20, 16'd100, 16'd200, 16'd500};
            stock = '{16'd10, 16'd20, 16'd0, 16'd200, 16'd50};
            mismatches = 0;
        endfunction

        function void set_face(logic [CFG_IDX_W-1:0] idx, t_value data);
            if (idx < NUM_REGS && idx < NUM_SLOTS)
                face[idx] = data;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void take_request(logic act, t_amount amt, t_value den, t_count cnt);
            t_payout     p;
            int unsigned rest;
            int unsigned want;
            int unsigned total;
            t_count      take [NUM_SLOTS];
            logic        hit;
            p = '0;
            if (act == ACT_WITHDRAW) begin
                p.status = ST_REFUSED;
                rest = amt;
                if (amt != 0) begin
                    // greedy walk, highest slot first
                    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
                        take[s] = '0;
                        if (face[s] != 0 && rest >= face[s]) begin
                            want = rest / face[s];
                            take[s] = (want < stock[s]) ? t_count'(want) : stock[s];
                            rest -= int'(take[s]) * int'(face[s]);
                        end
                    end
                    if (rest == 0) begin
                        p.status = ST_DISPENSED;
                        for (int s = 0; s < NUM_SLOTS; s++) begin
                            stock[s] -= take[s];
                            if (s < NUM_OUT_SLOTS)
                                p.notes[s] = take[s];
                        end
                    end
                end
            end else begin
                p.status = ST_UNKNOWN;
                hit = 1'b0;
                for (int s = 0; s < NUM_SLOTS; s++) begin
                    if (!hit && den != 0 && face[s] == den) begin
                        total = int'(stock[s]) + int'(cnt);
                        stock[s] = (total > 32'hFFFF) ? 16'hFFFF : t_count'(total);
                        p.status = ST_ACCEPTED;
                        hit = 1'b1;
                    end
                end
            end
            owed.push_back(p);
        endfunction

        function void match_payout(t_status got_status, t_count [NUM_OUT_SLOTS-1:0] got_notes);
            t_payout p;
            if (owed.size() == 0) begin
                $display("%0t: result word with none expected, status %0d", $time, got_status);
                mismatches++;
                return;
            end
            p = owed.pop_front();
            if (got_status !== p.status) begin
                $display("%0t: status expected %0d got %0d", $time, p.status, got_status);
                mismatches++;
            end
            for (int s = 0; s < NUM_OUT_SLOTS; s++) begin
                if (got_notes[s] !== p.notes[s]) begin
                    $display("%0t: slot %0d notes expected %0d got %0d",
                             $time, s, p.notes[s], got_notes[s]);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                 i_clk      = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 action     = ACT_WITHDRAW;
    t_amount              amount     = '0;
    t_value               deposit_den = '0;
    t_count               deposit_cnt = '0;
    logic                 out_ready  = 1'b0;
    logic                 cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    t_value               cfg_data   = '0;

    logic    o_in_ready;
    logic    o_out_valid;
    logic    o_cfg_ready;
    t_status o_status;
    t_count  o_notes_slot_0;
    t_count  o_notes_slot_1;
    t_count  o_notes_slot_2;
    t_count  o_notes_slot_3;
    t_count  o_notes_slot_4;

    cash_ledger ledger;
    t_value     next_faces [NUM_SLOTS];
    int         burst_left = 0;
    int         ready_run  = 0;
    int         ready_hold = 0;
    int         idle_cycles = 0;

    limited_stock_greedy_change_dispenser uut (
        .i_clk                  (i_clk),
        .i_rst_n                (rst_n),
        .i_in_valid             (in_valid),
        .o_in_ready             (o_in_ready),
        .i_action               (action),
        .i_withdraw_amount      (amount),
        .i_deposit_denomination (deposit_den),
        .i_deposit_count        (deposit_cnt),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (out_ready),
        .o_status               (o_status),
        .o_notes_slot_0         (o_notes_slot_0),
        .o_notes_slot_1         (o_notes_slot_1),
        .o_notes_slot_2         (o_notes_slot_2),
        .o_notes_slot_3         (o_notes_slot_3),
        .o_notes_slot_4         (o_notes_slot_4),
        .i_cfg_valid            (cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_index            (cfg_index),
        .i_cfg_data             (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // result monitor and receiver stall pattern
    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && out_ready)
            ledger.match_payout(o_status, {o_notes_slot_4, o_notes_slot_3, o_notes_slot_2,
                                           o_notes_slot_1, o_notes_slot_0});
        if (ready_run > 0) begin
            out_ready <= 1'b1;
            ready_run <= ready_run - 1;
        end else if (ready_hold > 0) begin
            out_ready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            out_ready <= 1'b1;
            ready_run <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
            ready_hold <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
    end

    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
                (cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_item(input logic act, input t_amount amt, input t_value den,
                             input t_count cnt);
        int gap;
        in_valid    <= 1'b1;
        action      <= act;
        amount      <= amt;
        deposit_den <= den;
        deposit_cnt <= cnt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        ledger.take_request(act, amt, den, cnt);
        // bursts of random length, random gaps between them
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 20);
            gap = $urandom_range(1, 30);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle_results();
        if (in_valid)
            in_valid <= 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_value data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        ledger.set_face(idx, data);
    endtask

    task automatic program_faces();
        settle_results();
        for (int r = 0; r < NUM_REGS; r++)
            write_reg(CFG_IDX_W'(r), next_faces[r]);
        // an index past the register list, must be ignored
        write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
                  t_value'($urandom()));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int          phase;
        int          pick;
        int unsigned sum;
        int unsigned cap;
        t_amount     amt;
        t_value      den;
        t_value      tmp;
        t_count      cnt;

        ledger = new();
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;

        // directed words at reset face values
        send_item(ACT_WITHDRAW, '0, '0, '0);
        send_item(ACT_WITHDRAW, 20'hFFFFF, '0, '0);
        send_item(ACT_WITHDRAW, 20'd5, '0, '0);
        send_item(ACT_WITHDRAW, 20'd10, '0, '0);
        send_item(ACT_WITHDRAW, 20'd380, '0, '0);
        send_item(ACT_WITHDRAW, 20'd100, '0, '0);
        send_item(ACT_DEPOSIT, '0, 16'd100, 16'd3);
        send_item(ACT_WITHDRAW, 20'd300, '0, '0);
        send_item(ACT_WITHDRAW, 20'd13, '0, '0);
        send_item(ACT_DEPOSIT, '0, 16'd7, 16'd5);
        send_item(ACT_DEPOSIT, '0, 16'd0, 16'd4);
        send_item(ACT_DEPOSIT, '0, 16'd500, 16'd0);
        send_item(ACT_DEPOSIT, '0, 16'd200, 16'hFFFF);
        send_item(ACT_DEPOSIT, 20'hFFFFF, 16'hFFFF, 16'hFFFF);
        send_item(ACT_WITHDRAW, 20'h80000, 16'hFFFF, 16'hFFFF);

        // repeated, zero and out-of-order face values
        next_faces = '{16'd20, 16'd20, 16'd0, 16'hFFFF, 16'd1};
        program_faces();
        send_item(ACT_DEPOSIT, '0, 16'd20, 16'd5);
        send_item(ACT_DEPOSIT, '0, 16'd0, 16'd9);
        send_item(ACT_WITHDRAW, 20'd100, '0, '0);
        send_item(ACT_WITHDRAW, 20'd65585, '0, '0);
        send_item(ACT_WITHDRAW, 20'hFFFFF, '0, '0);
        send_item(ACT_DEPOSIT, '0, 16'd1, 16'hFFFF);

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: next_faces = '{16'd10, 16'd20, 16'd100, 16'd200, 16'd500};
                1: next_faces = '{16'd1, 16'd2, 16'd5, 16'd10, 16'd20};
                3: next_faces = '{16'd1, 16'd1000, 16'd30000, 16'hFFFE, 16'hFFFF};
                4: begin
                    for (int s = 0; s < NUM_SLOTS; s++) begin
                        pick = $urandom_range(0, 4);
                        if (pick == 0)
                            next_faces[s] = '0;
                        else if (pick == 1 && s > 0)
                            next_faces[s] = next_faces[$urandom_range(0, s - 1)];
                        else
                            next_faces[s] = t_value'($urandom_range(1, 65535));
                    end
                end
                default: begin
                    // random ascending set
                    for (int s = 0; s < NUM_SLOTS; s++)
                        next_faces[s] = t_value'($urandom_range(1, (phase == 2) ? 65535 : 1000));
                    for (int i = 0; i < NUM_SLOTS - 1; i++) begin
                        for (int j = 0; j < NUM_SLOTS - 1 - i; j++) begin
                            if (next_faces[j] > next_faces[j + 1]) begin
                                tmp = next_faces[j];
                                next_faces[j] = next_faces[j + 1];
                                next_faces[j + 1] = tmp;
                            end
                        end
                    end
                end
            endcase
            program_faces();

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 2 && n == ITEMS_PER_PHASE / 2)
                    settle_results();
                pick = $urandom_range(0, 99);
                amt  = t_amount'($urandom());
                den  = t_value'($urandom());
                cnt  = t_count'($urandom());
                if (pick < 55) begin
                    // amount built from notes actually in stock, at times plus one, or random if none
                    sum = 0;
                    for (int s = 0; s < NUM_SLOTS; s++) begin
                        if (ledger.face[s] != 0 && ledger.stock[s] != 0) begin
                            cap = (ledger.face[s] > 4096) ? 2 : 8;
                            if (cap > ledger.stock[s])
                                cap = ledger.stock[s];
                            sum += $urandom_range(0, cap) * ledger.face[s];
                        end
                    end
                    if (sum == 0)
                        sum = $urandom_range(1, 5000);
                    if ($urandom_range(0, 9) == 0)
                        sum += 1;
                    send_item(ACT_WITHDRAW, t_amount'(sum), den, cnt);
                end else if (pick < 63) begin
                    send_item(ACT_WITHDRAW, amt, den, cnt);
                end else if (pick < 67) begin
                    send_item(ACT_WITHDRAW, t_amount'($urandom_range(1, 3000)), den, cnt);
                end else if (pick < 69) begin
                    send_item(ACT_WITHDRAW, '0, den, cnt);
                end else if (pick < 92) begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        cnt = 16'hFFFF;
                    else if (pick > 1)
                        cnt = t_count'($urandom_range(0, 100));
                    send_item(ACT_DEPOSIT, amt, ledger.face[$urandom_range(0, NUM_SLOTS - 1)],
                              cnt);
                end else begin
                    send_item(ACT_DEPOSIT, amt, den, cnt);
                end
            end
        end

        settle_results();
        repeat (END_WAIT) @(posedge i_clk);
        if (ledger.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lsgcd_pkg.sv
sv/limited_stock_greedy_change_dispenser.sv
sv/lsgcd_checker.sv
tb/tb_top.sv
